// ----- rtl/sgm_pkg.sv -----
// shared types and constants for the sobel gradient magnitude block
package sgm_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int ROW_W        = 13;
    localparam int PIX_W        = 8;
    localparam int GRAD_W       = 10;
    localparam int SQ_SUM_W     = 21;
    localparam int RAD_W        = 24;
    localparam int REM_W        = 13;
    localparam int MAG_W        = 12;
    localparam int TDATA_IN_W   = 8;
    localparam int TDATA_OUT_W  = 16;
    localparam int ROOT_STEPS   = 12;
    localparam int CNT_W        = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_GRAD,
        S_SQR,
        S_ROOT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic update;
        logic grad;
        logic square;
        logic root_step;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic has_result;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/sgm_ram.sv -----
// generic single write port ram with registered read
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sgm_ctrl.sv -----
// controller state machine sequencing one transaction through the datapath
module sgm_ctrl
    import sgm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (i_sts.skip || !i_sts.has_result) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_GRAD;
                end
            end
            S_GRAD: n_state = S_SQR;
            S_SQR:  n_state = S_ROOT;
            S_ROOT: begin
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        n_cnt = '0;
        case (r_state)
            S_IDLE: o_cmd.accept = i_s_tvalid;
            S_UPD:  o_cmd.update = 1'b1;
            S_GRAD: o_cmd.grad   = 1'b1;
            S_SQR:  o_cmd.square = 1'b1;
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
            end
            S_DONE: o_cmd.load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

// ----- rtl/sgm_datapath.sv -----
// datapath: positions, line buffers, 3x3 window, gradients, square root, output register
module sgm_datapath
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic [TDATA_IN_W-1:0]  i_s_tdata,
    input  logic                   i_s_tuser,
    input  logic                   i_m_tready,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    output logic                   o_m_tvalid,
    output logic [TDATA_OUT_W-1:0] o_m_tdata,
    output logic                   o_m_tlast
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    function automatic logic [GRAD_W-1:0] wsum(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] c);
        return GRAD_W'(a) + {1'b0, b, 1'b0} + GRAD_W'(c);
    endfunction

    function automatic logic [GRAD_W-1:0] absdiff(input logic [GRAD_W-1:0] a,
                                                  input logic [GRAD_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_HEIGHT_W-1:0] r_height;
    logic [AW-1:0]           r_col;
    logic [ROW_W-1:0]        r_row;
    logic [PIX_W-1:0]        r_win [3][3];
    logic                    r_cmd;
    logic [PIX_W-1:0]        r_smp;
    logic                    r_use_left;
    logic                    r_use_right;
    logic                    r_last;
    logic [GRAD_W-1:0]       r_ax;
    logic [GRAD_W-1:0]       r_ay;
    logic [RAD_W-1:0]        r_rad;
    logic [REM_W-1:0]        r_rem;
    logic [MAG_W-1:0]        r_root;
    logic                    r_out_valid;
    logic [MAG_W-1:0]        r_out_mag;
    logic                    r_out_last;

    logic [ROW_W-1:0]  w_ext;
    logic [ROW_W-1:0]  w_clamp;
    logic [WW-1:0]     w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic [AW-1:0]     c_eff;
    logic [WW-1:0]     c_inc;
    logic              in_image;
    logic              res_a;
    logic              res_b;
    logic              last;
    logic              skip;
    logic [PIX_W-1:0]  val;
    logic [PIX_W-1:0]  up;
    logic [PIX_W-1:0]  md;
    logic [PIX_W-1:0]  rd_upper;
    logic [PIX_W-1:0]  rd_mid;
    logic              line_we;
    logic [PIX_W-1:0]  lft [3];
    logic [PIX_W-1:0]  rgt [3];
    logic [2*GRAD_W-1:0] sq_x;
    logic [2*GRAD_W-1:0] sq_y;
    logic [SQ_SUM_W-1:0] sq_sum;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              bit_ok;

    // clamped frame geometry
    assign w_ext   = ROW_W'(r_width);
    assign w_clamp = (w_ext == '0) ? ROW_W'(1) :
                     (w_ext > ROW_W'(MAX_WIDTH)) ? ROW_W'(MAX_WIDTH) : w_ext;
    assign w_eff   = w_clamp[WW-1:0];
    assign h_eff   = (r_height == '0) ? ROW_W'(1) :
                     (r_height > CFG_HEIGHT_W'(HEIGHT_LIMIT)) ? ROW_W'(HEIGHT_LIMIT) : r_height;

    assign c_eff    = (WW'(r_col) >= w_eff) ? '0 : r_col;
    assign c_inc    = WW'(c_eff) + 1'b1;
    assign in_image = (r_row < h_eff);
    assign res_a    = (c_eff == '0) && (r_row >= ROW_W'(2));
    assign res_b    = (c_eff != '0) && (r_row >= ROW_W'(1));
    assign last     = res_a && (r_row == h_eff + 1'b1);
    assign skip     = in_image && (r_cmd == CMD_FLUSH);
    assign val      = in_image ? r_smp : '0;
    assign up       = (r_row >= ROW_W'(2)) ? rd_upper : '0;
    assign md       = (r_row >= ROW_W'(1)) ? rd_mid : '0;
    assign line_we  = i_cmd.update && !skip && !last;

    assign o_sts.skip       = skip;
    assign o_sts.has_result = res_a || res_b;
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    sgm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (c_eff),
        .i_wdata (rd_mid),
        .i_re    (i_cmd.accept),
        .i_raddr (c_eff),
        .o_rdata (rd_upper)
    );

    sgm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (c_eff),
        .i_wdata (val),
        .i_re    (i_cmd.accept),
        .i_raddr (c_eff),
        .o_rdata (rd_mid)
    );

    // configuration and frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_WIDTH_W'(1024);
            r_height <= CFG_HEIGHT_W'(1024);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata[CFG_HEIGHT_W-1:0];
                default:          r_width  <= r_width;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.update && !skip) begin
            if (last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (c_inc >= w_eff) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= c_inc[AW-1:0];
            end
        end
    end

    // 3x3 window, cleared on restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (i_cfg_we || (i_cmd.grad && r_last)) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (i_cmd.update && !skip) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= up;
            r_win[1][2] <= md;
            r_win[2][2] <= val;
        end
    end

    // transaction payload and per pixel flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_s_tuser;
            r_smp <= i_s_tdata[PIX_W-1:0];
        end
        if (i_cmd.update) begin
            r_use_left  <= res_a ? (w_eff >= WW'(2)) : (c_eff != AW'(1));
            r_use_right <= res_b;
            r_last      <= last;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lft[k] = r_use_left  ? r_win[k][0] : '0;
            rgt[k] = r_use_right ? r_win[k][2] : '0;
        end
    end

    assign sq_x   = r_ax * r_ax;
    assign sq_y   = r_ay * r_ay;
    assign sq_sum = SQ_SUM_W'(sq_x) + SQ_SUM_W'(sq_y);

    // one root bit per step
    assign rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign bit_ok = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_ax <= absdiff(wsum(rgt[0], rgt[1], rgt[2]), wsum(lft[0], lft[1], lft[2]));
            r_ay <= absdiff(wsum(lft[0], r_win[0][1], rgt[0]),
                            wsum(lft[2], r_win[2][1], rgt[2]));
        end
        if (i_cmd.square) begin
            r_rad  <= {1'b0, sq_sum, 2'b00};
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (bit_ok) begin
                r_rem  <= REM_W'(rem_sh - trial);
                r_root <= {r_root[MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[REM_W-1:0];
                r_root <= {r_root[MAG_W-2:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_mag  <= r_root;
            r_out_last <= r_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_OUT_W'(r_out_mag);
    assign o_m_tlast  = r_out_last;

endmodule

// ----- rtl/sobel_gradient_magnitude_top.sv -----
// top level of the streaming 3x3 sobel gradient magnitude block
//
// input stream: one 8-bit sample per transaction in raster order; tuser set
// marks a flush step. after the last sample of a frame, image_width+1 flush
// transactions push out the remaining results. flushes inside a frame are
// taken and dropped; once all samples arrived every transaction flushes.
// output stream: magnitude in units of 1/2, tlast on the last pixel of a frame.
// the result for pixel (r,c) comes with the transaction image_width+1 places later.
// a transaction with a result occupies the block through line buffer
// read, window update, gradient, squares, 12 steps of the bit serial square
// root (one root bit per cycle) and the hand-off to the output register.
// a transaction without a result ends after the update step.
// the output register holds a finished result while the receiver stalls;
// the next transaction is taken meanwhile and only waits at hand-off.
// reset clears positions, window and output valid; width and height reset
// to 1024. any register write restarts the frame. line buffers are not cleared.
module sobel_gradient_magnitude_top
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_tdata,   // sample[7:0]
    input  logic                   i_s_tuser,   // command[0]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [TDATA_OUT_W-1:0] o_m_tdata,   // magnitude[11:0], zero[15:12]
    output logic                   o_m_tlast
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sgm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sgm_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tready  (i_m_tready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.accept, w_cmd.update, w_cmd.grad, w_cmd.square,
                  w_cmd.root_step, w_cmd.load}))
        else $error("datapath commands overlap");

    a_accept_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |=> w_cmd.update)
        else $error("accepted transaction not processed");

    a_square_then_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.square |=> w_cmd.root_step)
        else $error("square root did not start");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (!o_m_tvalid || i_m_tready))
        else $error("output register overwritten");

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the streaming sobel gradient magnitude block
module tb_top
    import sgm_pkg::*;
;

    localparam int unsigned STUCK_LIMIT  = 1000;
    localparam int unsigned SETTLE_TAIL  = 24;
    localparam int unsigned RANDOM_ITEMS = 380;
    localparam int unsigned NO_STOP      = 32'hFFFF_FFFF;
    localparam int unsigned EXTREME_CUT  = 40;
    localparam int          N_DIRECTED   = 31;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic              sel;      // register index or command
        int unsigned       value;    // register value or sample
        bit                typed;
        logic [MAG_W-1:0]  mag;
        logic              last;
    } t_stim_row;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             last;
    } t_pixel_result;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;

    // predictor state
    bit   [PIX_W-1:0] upper_row [MAX_WIDTH_DEF];
    bit   [PIX_W-1:0] middle_row [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] win [9];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      width_reg;
    int unsigned      height_reg;

    t_pixel_result pending_pixels [$];
    t_stim_row     directed [N_DIRECTED];

    int unsigned items_accepted    = 0;
    int unsigned items_dropped     = 0;
    int unsigned results_predicted = 0;
    int unsigned results_checked   = 0;
    int unsigned frames_done       = 0;
    int unsigned fails             = 0;
    int unsigned stuck_cycles      = 0;
    bit          no_idling         = 1'b0;

    sobel_gradient_magnitude_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return height_reg;
    endfunction

    function automatic void restart_frame();
        for (int k = 0; k < 9; k++) win[k] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic int unsigned floor_root(input int unsigned v);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int b = MAG_W - 1; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic logic [MAG_W-1:0] sobel_magnitude(input int lft[3], input int mid[3],
                                                        input int rgt[3]);
        int gx;
        int gy;
        gx = (rgt[0] + 2 * rgt[1] + rgt[2]) - (lft[0] + 2 * lft[1] + lft[2]);
        gy = (lft[0] + 2 * mid[0] + rgt[0]) - (lft[2] + 2 * mid[2] + rgt[2]);
        return MAG_W'(floor_root(4 * (gx * gx + gy * gy)));
    endfunction

    // advance the predictor by one accepted transaction
    function automatic void sobel_step(input logic cmd, input logic [PIX_W-1:0] smp);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int lft[3];
        int mid[3];
        int rgt[3];
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] md;
        w = eff_width();
        h = eff_height();
        r = row_pos;
        c = (col_pos >= w) ? 0 : col_pos;
        items_accepted++;
        if (r < h && cmd == CMD_FLUSH) begin
            items_dropped++;
            return;
        end
        pix = (r < h) ? smp : '0;
        // last pixel of the previous row, right neighbour outside
        if (c == 0 && r >= 2) begin
            for (int k = 0; k < 3; k++) begin
                lft[k] = (w >= 2) ? int'(win[3 * k + 1]) : 0;
                mid[k] = win[3 * k + 2];
                rgt[k] = 0;
            end
            pending_pixels.push_back('{sobel_magnitude(lft, mid, rgt), r == h + 1});
            results_predicted++;
            if (r == h + 1) begin
                frames_done++;
                restart_frame();
                return;
            end
        end
        up = (r >= 2) ? upper_row[c] : '0;
        md = (r >= 1) ? middle_row[c] : '0;
        upper_row[c]  = middle_row[c];
        middle_row[c] = pix;
        for (int k = 0; k < 3; k++) begin
            win[3 * k]     = win[3 * k + 1];
            win[3 * k + 1] = win[3 * k + 2];
        end
        win[2] = up;
        win[5] = md;
        win[8] = pix;
        if (c >= 1 && r >= 1) begin
            for (int k = 0; k < 3; k++) begin
                lft[k] = (c == 1) ? 0 : int'(win[3 * k]);
                mid[k] = win[3 * k + 1];
                rgt[k] = win[3 * k + 2];
            end
            pending_pixels.push_back('{sobel_magnitude(lft, mid, rgt), 1'b0});
            results_predicted++;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r % (1 << ROW_W);
    endfunction

    task automatic report_mismatch(input string what);
        fails++;
        // keep the log short when everything goes wrong
        if (fails <= 50) $display("tb_top: mismatch at %0t: %s", $time, what);
    endtask

    // entered and left at a falling edge
    task automatic send_item(input logic cmd, input logic [PIX_W-1:0] smp);
        if (!no_idling && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do @(posedge clk); while (!s_tready);
        sobel_step(cmd, smp);
        @(negedge clk);
    endtask

    task automatic settle(input int unsigned tail);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        settle(SETTLE_TAIL);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) width_reg = value[CFG_WIDTH_W-1:0];
        else height_reg = value[CFG_HEIGHT_W-1:0];
        restart_frame();
    endtask

    // one frame of random samples, optionally cut short; a full frame is followed by its flush steps
    task automatic send_frame(input int unsigned stop_at, input int unsigned noise_pct);
        int unsigned w;
        int unsigned h;
        int unsigned i;
        logic [PIX_W-1:0] pix;
        w = eff_width();
        h = eff_height();
        for (i = 0; i < w * h; i++) begin
            if (i == stop_at) return;
            case ($urandom_range(0, 3))
                0:       pix = '0;
                1:       pix = '1;
                default: pix = PIX_W'($urandom);
            endcase
            if ($urandom_range(0, 99) < noise_pct) send_item(CMD_FLUSH, PIX_W'($urandom));
            send_item(CMD_SAMPLE, pix);
        end
        for (i = 0; i <= w; i++) begin
            send_item(($urandom_range(0, 3) == 0) ? CMD_SAMPLE : CMD_FLUSH, PIX_W'($urandom));
        end
    endtask

    // receiver with bursts of back-pressure
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!no_idling && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_pixel_result want;
        if (m_tvalid && m_tready) begin
            results_checked++;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("result %0h with nothing expected", m_tdata));
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[MAG_W-1:0] !== want.mag)
                    report_mismatch($sformatf("magnitude %0d, expected %0d",
                                              m_tdata[MAG_W-1:0], want.mag));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.last));
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        int unsigned base;
        int unsigned prior_count;
        int unsigned pick;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        width_reg  = MAX_WIDTH_DEF;
        height_reg = 1024;
        restart_frame();

        directed = '{
            // default geometry: part of a row, a flush inside the frame, then restart
            '{ROW_ITEM, CMD_SAMPLE, 255, 1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 0,   1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_FLUSH,  0,   1'b0, 12'd0, 1'b0},
            // zero width and height count as one: single pixel has no gradient
            '{ROW_CFG,  REG_IMAGE_WIDTH,  0, 1'b0, 12'd0, 1'b0},
            '{ROW_CFG,  REG_IMAGE_HEIGHT, 0, 1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 255, 1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_FLUSH,  0,   1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_FLUSH,  0,   1'b1, 12'd0, 1'b1},
            // 2x1 frame with a full step, sample acting as the last flush
            '{ROW_CFG,  REG_IMAGE_WIDTH,  2, 1'b0, 12'd0, 1'b0},
            '{ROW_CFG,  REG_IMAGE_HEIGHT, 1, 1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 255, 1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_FLUSH,  0,   1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 0,   1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_FLUSH,  0,   1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_FLUSH,  0,   1'b1, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 77,  1'b1, 12'd1020, 1'b1},
            // 3x3 checkerboard
            '{ROW_CFG,  REG_IMAGE_WIDTH,  3, 1'b0, 12'd0, 1'b0},
            '{ROW_CFG,  REG_IMAGE_HEIGHT, 3, 1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 255, 1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 0,   1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 255, 1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 0,   1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 255, 1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 0,   1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 255, 1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 0,   1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 255, 1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_FLUSH,  0,   1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_SAMPLE, 200, 1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_FLUSH,  0,   1'b0, 12'd0, 1'b0},
            '{ROW_ITEM, CMD_FLUSH,  0,   1'b0, 12'd0, 1'b0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int n = 0; n < N_DIRECTED; n++) begin
            if (directed[n].kind == ROW_CFG) begin
                write_register(directed[n].sel, directed[n].value);
            end else begin
                prior_count = results_predicted;
                send_item(directed[n].sel, PIX_W'(directed[n].value));
                if (directed[n].typed && results_predicted != prior_count)
                    pending_pixels[$] = '{directed[n].mag, directed[n].last};
            end
        end

        // largest register values, frames cut short and restarted
        write_register(REG_IMAGE_WIDTH, 2047);
        write_register(REG_IMAGE_HEIGHT, 2);
        send_frame(EXTREME_CUT, 2);
        write_register(REG_IMAGE_WIDTH, MAX_WIDTH_DEF);
        write_register(REG_IMAGE_HEIGHT, HEIGHT_LIMIT);
        send_frame(EXTREME_CUT, 2);
        write_register(REG_IMAGE_WIDTH, 1);
        write_register(REG_IMAGE_HEIGHT, 8191);
        send_frame(EXTREME_CUT, 2);

        write_register(REG_IMAGE_WIDTH, 4);
        write_register(REG_IMAGE_HEIGHT, 3);
        base = items_accepted;
        while (items_accepted - base < RANDOM_ITEMS) begin
            if (items_accepted - base > RANDOM_ITEMS - 100) no_idling = 1'b1;
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       pick = 0;
                    1:       pick = $urandom_range(9, 40);
                    default: pick = $urandom_range(1, 8);
                endcase
                write_register(REG_IMAGE_WIDTH, pick);
                if ($urandom_range(0, 1) == 1)
                    write_register(REG_IMAGE_HEIGHT,
                                   ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
            end
            if ($urandom_range(0, 7) == 0) begin
                // abandon the frame part way and restart it with a write
                send_frame($urandom_range(0, eff_width() * eff_height() - 1), 10);
                write_register(REG_IMAGE_HEIGHT, height_reg);
            end else begin
                send_frame(NO_STOP, 10);
            end
        end

        settle(30);
        $display("tb_top: %0d transactions, %0d in-frame flushes dropped, %0d results checked",
                 items_accepted, items_dropped, results_checked);
        $display("tb_top: %0d frames completed up to 40 wide, largest register values on cut frames",
                 frames_done);
        if (fails == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
